FILE: src/hng_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hng_pkg
// Shared types, constants and arithmetic helpers of the normal generator.
// ----------------------------------------------------------------------------
package hng_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int COL_W      = 8;
	localparam int ROW_W      = 12;
	localparam int HGT_W      = 16;
	localparam int Q_W        = 15;
	localparam int QDEPTH     = 4;
	localparam int QAW        = 2;
	localparam int S_W        = 34;
	localparam int P_W        = 66;
	localparam int TS_W       = 52;
	localparam int R_W        = 62;

	// configuration register indexes
	localparam logic [1:0] CFG_MAP_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_MAP_HEIGHT = 2'd1;

	// one normal to compute: centre sample and its two neighbors
	typedef struct packed {
		logic [HGT_W-1:0] centre;
		logic [HGT_W-1:0] right;
		logic [HGT_W-1:0] below;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             done;
	} job_t;

	typedef struct packed {
		logic            take;
		logic [P_W-1:0]  p;
		logic [TS_W-1:0] ts;
	} qstep_t;

	// One bit of the quotient search. With t = 2q-1, p = t*t*s and ts = t*s,
	// try q + 2^b: t grows by 2^(b+1); keep it if t'^2 * s <= r.
	function automatic qstep_t quot_step(input logic [P_W-1:0] p,
		input logic [TS_W-1:0] ts, input logic [S_W-1:0] s,
		input logic [R_W-1:0] r, input logic [3:0] b);
		logic signed [67:0] pc;
		logic signed [67:0] tsx;
		logic [67:0]        sx;
		qstep_t             res;
		tsx = {{(68-TS_W){ts[TS_W-1]}}, ts};
		sx  = {{(68-S_W){1'b0}}, s};
		pc  = $signed({2'b00, p}) + (tsx <<< ({1'b0, b} + 5'd2))
			+ $signed(sx << ({1'b0, b, 1'b0} + 6'd2));
		res.take = (pc[67] == 1'b0) && (pc <= $signed({6'd0, r}));
		res.p    = res.take ? pc[P_W-1:0] : p;
		res.ts   = res.take ? (ts + TS_W'(sx << (b + 4'd1))) : ts;
		return res;
	endfunction

endpackage

FILE: src/hng_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hng_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hng_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: src/hng_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hng_front
// Accepts height samples, keeps the row stores and counters, and turns each
// sample into zero to three normal jobs.
// ----------------------------------------------------------------------------
module hng_front
	import hng_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [HGT_W-1:0] in_height,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [11:0]      cfg_data,
	output logic             job_valid,
	input  logic             job_ready,
	output job_t             job
);

	typedef enum logic [3:0] {
		F_IDLE = 4'b0001,
		F_RD   = 4'b0010,
		F_GET  = 4'b0100,
		F_EMIT = 4'b1000
	} fstate_t;

	fstate_t          state_q;
	logic [8:0]       width_q;
	logic [11:0]      height_q;
	logic [8:0]       w_eff;
	logic [11:0]      h_eff;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [HGT_W-1:0] prev_first_q, cur_first_q;
	logic [HGT_W-1:0] hv_s1, lh_q, rc_q, rn_q, tc_q, tp_q;
	logic [COL_W-1:0] c_s1;
	logic [ROW_W-1:0] r_s1;
	logic [2:0]       mask_q;
	logic             accept;
	logic             row_last, col_last;
	logic [COL_W-1:0] row_raddr, top_raddr;
	logic [HGT_W-1:0] row_rdata, top_rdata;

	// saturated effective dimensions
	always_comb begin
		w_eff = width_q;
		if (width_q < 9'd2) w_eff = 9'd2;
		if (width_q > 9'(MAX_WIDTH)) w_eff = 9'(MAX_WIDTH);
		h_eff = (height_q < 12'd2) ? 12'd2 : height_q;
	end

	assign in_ready  = (state_q == F_IDLE);
	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign row_last  = (r_s1 == h_eff - 12'd1);
	assign col_last  = ({1'b0, c_s1} == w_eff - 9'd1);

	// read addresses: current column at accept, then neighbors
	always_comb begin
		row_raddr = col_q;
		top_raddr = col_q;
		if (state_q == F_RD) begin
			row_raddr = c_s1 + 8'd1;
			top_raddr = c_s1 - 8'd1;
		end
	end

	hng_ram #(.WIDTH(HGT_W), .DEPTH(MAX_WIDTH)) u_row_store (
		.clk   (clk),
		.we    (state_q == F_GET),
		.waddr (c_s1),
		.wdata (hv_s1),
		.raddr (row_raddr),
		.rdata (row_rdata)
	);

	hng_ram #(.WIDTH(HGT_W), .DEPTH(MAX_WIDTH)) u_top_store (
		.clk   (clk),
		.we    ((state_q == F_GET) && (r_s1 == '0)),
		.waddr (c_s1),
		.wdata (hv_s1),
		.raddr (top_raddr),
		.rdata (top_rdata)
	);

	// sequencer, counters and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= F_IDLE;
			width_q      <= 9'd256;
			height_q     <= 12'd256;
			col_q        <= '0;
			row_q        <= '0;
			prev_first_q <= '0;
			cur_first_q  <= '0;
			mask_q       <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						if (col_q == '0) begin
							prev_first_q <= cur_first_q;
							cur_first_q  <= in_height;
						end
						if ({1'b0, col_q} + 9'd1 == w_eff) begin
							col_q <= '0;
							row_q <= (row_q + 12'd1 == h_eff) ? '0 : row_q + 12'd1;
						end else begin
							col_q <= col_q + 8'd1;
						end
						state_q <= F_RD;
					end
				end
				F_RD: state_q <= F_GET;
				F_GET: begin
					mask_q  <= {row_last && col_last, row_last && (c_s1 != '0),
						r_s1 != '0};
					state_q <= F_EMIT;
				end
				F_EMIT: begin
					if (mask_q == '0) begin
						state_q <= F_IDLE;
					end else if (job_ready) begin
						if (mask_q[0]) mask_q[0] <= 1'b0;
						else if (mask_q[1]) mask_q[1] <= 1'b0;
						else mask_q[2] <= 1'b0;
					end
				end
				default: state_q <= F_IDLE;
			endcase
			if (cfg_valid) begin
				if (cfg_index == CFG_MAP_WIDTH) begin
					width_q <= cfg_data[8:0];
					col_q   <= '0;
					row_q   <= '0;
				end else if (cfg_index == CFG_MAP_HEIGHT) begin
					height_q <= cfg_data;
					col_q    <= '0;
					row_q    <= '0;
				end
			end
		end
	end

	// sample and neighbor capture
	always_ff @(posedge clk) begin
		if (accept) begin
			lh_q  <= hv_s1;
			hv_s1 <= in_height;
			c_s1  <= col_q;
			r_s1  <= row_q;
		end
		if (state_q == F_RD) begin
			rc_q <= row_rdata;
			tc_q <= top_rdata;
		end
		if (state_q == F_GET) begin
			rn_q <= ({1'b0, c_s1} + 9'd1 < w_eff) ? row_rdata : prev_first_q;
			tp_q <= top_rdata;
		end
	end

	// job selection, lowest pending first
	always_comb begin
		job_valid = (state_q == F_EMIT) && (mask_q != '0);
		job.done  = 1'b0;
		if (mask_q[0]) begin
			job.centre = rc_q;
			job.right  = rn_q;
			job.below  = hv_s1;
			job.col    = c_s1;
			job.row    = r_s1 - 12'd1;
		end else if (mask_q[1]) begin
			job.centre = lh_q;
			job.right  = hv_s1;
			job.below  = tp_q;
			job.col    = c_s1 - 8'd1;
			job.row    = r_s1;
		end else begin
			job.centre = hv_s1;
			job.right  = cur_first_q;
			job.below  = tc_q;
			job.col    = c_s1;
			job.row    = r_s1;
			job.done   = 1'b1;
		end
	end

endmodule

FILE: src/hng_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hng_queue
// Small job FIFO between the sample front end and the normal unit.
// ----------------------------------------------------------------------------
module hng_queue
	import hng_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  job_t in_job,
	output logic out_valid,
	input  logic out_ready,
	output job_t out_job
);

	job_t           mem_q [QDEPTH];
	logic [QAW-1:0] wptr_q, rptr_q;
	logic [QAW:0]   count_q;
	logic           push, pop;

	assign in_ready  = (count_q != (QAW+1)'(QDEPTH));
	assign out_valid = (count_q != '0);
	assign out_job   = mem_q[rptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop) rptr_q <= rptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= in_job;
	end

endmodule

FILE: src/hng_norm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hng_norm
// Normalizes one (i, 1.0, k) vector: squares, length term, then a 15-step
// bit search per component, and an output register.
// ----------------------------------------------------------------------------
module hng_norm
	import hng_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        job_valid,
	output logic        job_ready,
	input  job_t        job,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [71:0] out_data,
	output logic        out_last
);

	typedef enum logic [4:0] {
		B_IDLE = 5'b00001,
		B_SQ   = 5'b00010,
		B_SUM  = 5'b00100,
		B_ITER = 5'b01000,
		B_DONE = 5'b10000
	} bstate_t;

	bstate_t          state_q;
	logic [16:0]      di_s1, dk_s1;
	logic [15:0]      ai, ak;
	logic [31:0]      ai2_s2, ak2_s2;
	logic [S_W-1:0]   s_q;
	logic [R_W-1:0]   rx_q, rz_q, ry_q;
	logic [P_W-1:0]   px_q, py_q, pz_q;
	logic [TS_W-1:0]  tx_q, ty_q, tz_q;
	logic [Q_W-1:0]   qx_q, qy_q, qz_q;
	logic [3:0]       bit_q;
	logic [COL_W-1:0] col_s1;
	logic [ROW_W-1:0] row_s1;
	logic             done_s1;
	qstep_t           stx, sty, stz;
	logic [15:0]      nx, nz;
	logic             load;

	assign job_ready = (state_q == B_IDLE);
	assign ai = di_s1[16] ? 16'(-di_s1) : di_s1[15:0];
	assign ak = dk_s1[16] ? 16'(-dk_s1) : dk_s1[15:0];

	assign stx = quot_step(px_q, tx_q, s_q, rx_q, bit_q);
	assign sty = quot_step(py_q, ty_q, s_q, ry_q, bit_q);
	assign stz = quot_step(pz_q, tz_q, s_q, rz_q, bit_q);

	assign nx   = di_s1[16] ? 16'(-$signed({1'b0, qx_q})) : {1'b0, qx_q};
	assign nz   = dk_s1[16] ? 16'(-$signed({1'b0, qz_q})) : {1'b0, qz_q};
	assign load = (state_q == B_DONE) && (!out_valid || out_ready);

	// sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			out_valid <= 1'b0;
			bit_q     <= '0;
		end else begin
			case (state_q)
				B_IDLE: if (job_valid) state_q <= B_SQ;
				B_SQ:   state_q <= B_SUM;
				B_SUM: begin
					bit_q   <= 4'd14;
					state_q <= B_ITER;
				end
				B_ITER: begin
					if (bit_q == '0) state_q <= B_DONE;
					else bit_q <= bit_q - 4'd1;
				end
				B_DONE: if (load) state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
			if (load) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (job_valid && job_ready) begin
			di_s1   <= {job.centre[15], job.centre} - {job.right[15], job.right};
			dk_s1   <= {job.centre[15], job.centre} - {job.below[15], job.below};
			col_s1  <= job.col;
			row_s1  <= job.row;
			done_s1 <= job.done;
		end
		if (state_q == B_SQ) begin
			ai2_s2 <= ai * ai;
			ak2_s2 <= ak * ak;
		end
		if (state_q == B_SUM) begin
			s_q  <= {2'b00, ai2_s2} + {2'b00, ak2_s2} + 34'd65536;
			rx_q <= {ai2_s2, 30'd0};
			rz_q <= {ak2_s2, 30'd0};
			ry_q <= R_W'(1) << 46;
			px_q <= P_W'({2'b00, ai2_s2} + {2'b00, ak2_s2} + 34'd65536);
			py_q <= P_W'({2'b00, ai2_s2} + {2'b00, ak2_s2} + 34'd65536);
			pz_q <= P_W'({2'b00, ai2_s2} + {2'b00, ak2_s2} + 34'd65536);
			tx_q <= -TS_W'({2'b00, ai2_s2} + {2'b00, ak2_s2} + 34'd65536);
			ty_q <= -TS_W'({2'b00, ai2_s2} + {2'b00, ak2_s2} + 34'd65536);
			tz_q <= -TS_W'({2'b00, ai2_s2} + {2'b00, ak2_s2} + 34'd65536);
			qx_q <= '0;
			qy_q <= '0;
			qz_q <= '0;
		end
		if (state_q == B_ITER) begin
			px_q <= stx.p;
			tx_q <= stx.ts;
			qx_q[bit_q] <= stx.take;
			py_q <= sty.p;
			ty_q <= sty.ts;
			qy_q[bit_q] <= sty.take;
			pz_q <= stz.p;
			tz_q <= stz.ts;
			qz_q[bit_q] <= stz.take;
		end
		if (load) begin
			out_data <= {5'd0, row_s1, col_s1, nz, qy_q, nx};
			out_last <= done_s1;
		end
	end

endmodule

FILE: src/heightmap_normal_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heightmap_normal_generator_top
// Height samples in, unit surface normals out.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one signed Q8.8 height sample per transfer, raster order.
//   m_* carries one normal per transfer; m_tlast marks the last of the map.
//   cfg_* writes map_width (index 0) or map_height (index 1); either write
//   restarts the frame. Write only while the block is idle.
//   Each sample walks the front-end states idle, read, get and emit: it
//   reads the row stores (one read port each) and then hands 0 to 3
//   jobs to a 4-entry queue. The normal unit steps through accept,
//   square, sum, 15 quotient steps and output load per result, and
//   takes a new job only after the last result has been loaded.
//   Reset clears the counters and sets both dimensions to 256; the row
//   stores need no clearing. When m_tready is low the result holds, the
//   normal unit stalls, the queue fills and then s_tready drops.
// ----------------------------------------------------------------------------
module heightmap_normal_generator_top
	import hng_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] height
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // [15:0] norm_x, [30:16] norm_y, [46:31] norm_z,
	                               // [54:47] pixel_col, [66:55] pixel_row
	output logic        m_tlast,   // frame_done
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data
);

	logic fq_valid, fq_ready, qn_valid, qn_ready;
	job_t fq_job, qn_job;

	hng_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_height (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.job_valid (fq_valid),
		.job_ready (fq_ready),
		.job       (fq_job)
	);

	hng_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_job    (fq_job),
		.out_valid (qn_valid),
		.out_ready (qn_ready),
		.out_job   (qn_job)
	);

	hng_norm u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (qn_valid),
		.job_ready (qn_ready),
		.job       (qn_job),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_last  (m_tlast)
	);

endmodule
